FILE: src/rcfw_pkg.sv
// ----------------------------------------------------------------------------
// rcfw_pkg
// Shared widths, codes, palette and state type of the radial colour fade wave.
// ----------------------------------------------------------------------------
package rcfw_pkg;

  localparam int MaxLedsDefault = 64;
  localparam int PaletteSize    = 6;
  // A wave is finished once the frame step exceeds four times the step count.
  localparam int WaveShift      = 2;

  localparam int StepW    = 16;
  localparam int TimeW    = 32;
  localparam int CountW   = 7;
  localparam int LedW     = 6;
  localparam int ChanW    = 8;
  localparam int ColW     = 3;
  localparam int FrameW   = 18;
  localparam int ProdW    = 24;
  localparam int DivCntW  = 5;
  localparam int InDataW  = 48;
  localparam int OutDataW = 32;
  localparam int AddrW    = 4;
  localparam int ApbW     = 32;

  localparam logic [1:0] RegFadeSteps = 2'd0;
  localparam logic [1:0] RegDelayMs   = 2'd1;
  localparam logic [1:0] RegLedCount  = 2'd2;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdTick  = 1'b1;

  localparam logic [1:0] ChRed   = 2'd0;
  localparam logic [1:0] ChGreen = 2'd1;
  localparam logic [1:0] ChBlue  = 2'd2;

  localparam logic [ProdW-1:0] Palette [PaletteSize] = '{
    24'h007A06,
    24'h7A5500,
    24'h7A0200,
    24'h70047A,
    24'h7A6E03,
    24'h276E6C
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SDIV,
    ST_LMUL,
    ST_LSTEP,
    ST_CMUL,
    ST_CLOAD,
    ST_CDIV,
    ST_CFIN,
    ST_EMIT,
    ST_FILL
  } state_e;

  // One channel of one palette entry; indexes above the palette read the last entry.
  function automatic logic [ChanW-1:0] pal_chan(logic [ColW-1:0] idx, logic [1:0] ch);
    logic [ProdW-1:0] c;
    case (idx)
      3'd0:    c = Palette[0];
      3'd1:    c = Palette[1];
      3'd2:    c = Palette[2];
      3'd3:    c = Palette[3];
      3'd4:    c = Palette[4];
      default: c = Palette[5];
    endcase
    case (ch)
      ChRed:   return c[23:16];
      ChGreen: return c[15:8];
      default: return c[7:0];
    endcase
  endfunction

endpackage

FILE: src/radial_colour_fade_wave_unit.sv
// ----------------------------------------------------------------------------
// radial_colour_fade_wave_unit
// LED strip effect engine: colour fill and radial fade waves over a palette.
// ----------------------------------------------------------------------------
// Usage: an item on the slave stream is a command in tuser (0 start, 1 frame
// tick) with the current millisecond time, a random origin LED and a random
// palette index in tdata. The block answers with one item per LED on the
// master stream, in LED order, with tlast on the final LED of the frame.
// A start item fills the strip with one palette colour. A tick may start a
// new wave when the delay has elapsed; a tick on a finished wave yields no
// items and returns the block to idle. Otherwise a shared 16 by 8 multiplier
// and a shared restoring divider that retires one quotient bit a cycle do
// all arithmetic. Per LED one multiply gives its step, then per channel one
// multiply and an eight-bit division. The stride division at the head of a
// frame yields a sixteen-bit quotient. s_axis_tready is high only while the
// block is idle. A result waits in an output register; when the receiver
// stalls the sequencer simply holds. Reset loads the register defaults
// (100 steps, 1000 ms, 60 LEDs) and clears the wave state. Registers sit on
// an APB port at 0x0, 0x4 and 0x8.
module radial_colour_fade_wave_unit #(
  parameter int MaxLeds = rcfw_pkg::MaxLedsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // now_ms [31:0], random_origin [38:32], random_colour [41:39], zero [47:42]
  input  logic [rcfw_pkg::InDataW-1:0]   s_axis_tdata,
  // command
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // led_index [5:0], red [13:6], green [21:14], blue [29:22], zero [31:30]
  output logic [rcfw_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcfw_pkg::AddrW-1:0]     paddr,
  input  logic [rcfw_pkg::ApbW-1:0]      pwdata,
  output logic [rcfw_pkg::ApbW-1:0]      prdata,
  output logic                           pready
);
  import rcfw_pkg::*;

  // Configuration registers.
  logic [StepW-1:0]  fade_steps_q;
  logic [TimeW-1:0]  delay_ms_q;
  logic [CountW-1:0] led_count_q;

  // Wave state.
  logic [ColW-1:0]   cur_idx_q, nxt_idx_q;
  logic [CountW-1:0] origin_q;
  logic [FrameW-1:0] frame_step_q;
  logic [TimeW-1:0]  last_change_q;

  // Sequencer.
  state_e            state_q, state_d;
  logic [LedW-1:0]   led_q;
  logic [1:0]        ch_q;

  // Shared divider.
  logic [StepW-1:0]   dv_rem_q, dv_sh_q, dv_div_q;
  logic [DivCntW-1:0] dv_cnt_q;

  // Datapath registers.
  logic [StepW-1:0]  stride_q;
  logic [ProdW-1:0]  prod_q;
  logic [StepW-1:0]  lstep_q;
  logic [ChanW-1:0]  chan_q [3];

  // Output register.
  logic                m_valid_q;
  logic                m_last_q;
  logic [OutDataW-1:0] m_data_q;

  // Derived values.
  logic [CountW-1:0] n_leds;
  logic [LedW-1:0]   last_idx;
  logic              last_led;
  logic [StepW-1:0]  steps;
  logic [FrameW-1:0] span;
  logic              wave_done;

  logic [TimeW-1:0]  in_now;
  logic [CountW-1:0] in_origin, origin_sat;
  logic [ColW-1:0]   in_colour, colour_sat;
  logic              in_accept;
  logic              wave_due;

  logic [StepW:0]    dv_trial, dv_sub;
  logic              dv_ge;
  logic [StepW-1:0]  dv_rem_nx;
  logic              dv_last;

  logic [CountW-1:0] led_ext, led_dist;
  logic [ChanW-1:0]  cur_c, nxt_c, chan_diff, quo, chan_res;
  logic              up;
  logic [StepW-1:0]  mul_a;
  logic [ChanW-1:0]  mul_b;
  logic [ProdW-1:0]  product;
  logic [FrameW-1:0] ls_diff;
  logic [StepW-1:0]  lstep;

  logic              slot_free;
  logic              out_load;
  logic              cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are free.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[AddrW-1:2])
      RegFadeSteps: prdata = ApbW'(fade_steps_q);
      RegDelayMs:   prdata = delay_ms_q;
      RegLedCount:  prdata = ApbW'(led_count_q);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Register values as used: strip length clamped, zero steps act as one.
  // --------------------------------------------------------------------------
  always_comb begin
    if (led_count_q < CountW'(2)) begin
      n_leds = CountW'(2);
    end else if (led_count_q > CountW'(MaxLeds)) begin
      n_leds = CountW'(MaxLeds);
    end else begin
      n_leds = led_count_q;
    end
  end

  assign last_idx  = LedW'(n_leds - CountW'(1));
  assign last_led  = (led_q == last_idx);
  assign steps     = (fade_steps_q == '0) ? StepW'(1) : fade_steps_q;
  assign span      = FrameW'({2'b00, steps} << WaveShift);
  assign wave_done = (frame_step_q > span);

  // --------------------------------------------------------------------------
  // Input item fields.
  // --------------------------------------------------------------------------
  assign in_now     = s_axis_tdata[31:0];
  assign in_origin  = s_axis_tdata[38:32];
  assign in_colour  = s_axis_tdata[41:39];
  assign colour_sat = (in_colour > ColW'(PaletteSize - 1)) ? ColW'(PaletteSize - 1) : in_colour;
  assign origin_sat = (in_origin > n_leds) ? n_leds : in_origin;
  assign in_accept  = s_axis_tvalid & s_axis_tready;
  // Wrapping time difference against the delay.
  assign wave_due   = ((in_now - last_change_q) > delay_ms_q);

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per cycle. The shift register holds
  // the dividend bits still to come and collects quotient bits from below.
  // --------------------------------------------------------------------------
  assign dv_trial  = {dv_rem_q, dv_sh_q[StepW-1]};
  assign dv_sub    = dv_trial - {1'b0, dv_div_q};
  assign dv_ge     = (dv_trial >= {1'b0, dv_div_q});
  assign dv_rem_nx = dv_ge ? dv_sub[StepW-1:0] : dv_trial[StepW-1:0];
  assign dv_last   = (dv_cnt_q == DivCntW'(1));

  // --------------------------------------------------------------------------
  // Per LED and per channel arithmetic around the shared multiplier.
  // --------------------------------------------------------------------------
  assign led_ext  = {1'b0, led_q};
  assign led_dist = (origin_q > led_ext) ? (origin_q - led_ext) : (led_ext - origin_q);

  assign cur_c     = pal_chan(cur_idx_q, ch_q);
  assign nxt_c     = pal_chan(nxt_idx_q, ch_q);
  assign up        = (nxt_c >= cur_c);
  assign chan_diff = up ? (nxt_c - cur_c) : (cur_c - nxt_c);

  assign mul_a   = (state_q == ST_LMUL) ? stride_q : lstep_q;
  assign mul_b   = (state_q == ST_LMUL) ? {1'b0, led_dist} : chan_diff;
  assign product = ProdW'(mul_a) * ProdW'(mul_b);

  // The LED's step is the frame step less stride times distance, clamped.
  assign ls_diff = frame_step_q - prod_q[FrameW-1:0];
  always_comb begin
    if (prod_q > ProdW'(frame_step_q)) begin
      lstep = '0;
    end else if (ls_diff > FrameW'(steps)) begin
      lstep = steps;
    end else begin
      lstep = ls_diff[StepW-1:0];
    end
  end

  // Rising channels round down; falling channels take the quotient rounded up.
  assign quo      = dv_sh_q[ChanW-1:0];
  assign chan_res = up ? (cur_c + quo) : (cur_c - quo - ChanW'(dv_rem_q != '0));

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  assign slot_free     = ~m_valid_q | m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser == CmdStart) ? ST_FILL : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = wave_done ? ST_IDLE : ST_SDIV;
      end
      ST_SDIV: begin
        if (dv_last) begin
          state_d = ST_LMUL;
        end
      end
      ST_LMUL:  state_d = ST_LSTEP;
      ST_LSTEP: state_d = ST_CMUL;
      ST_CMUL:  state_d = ST_CLOAD;
      ST_CLOAD: state_d = ST_CDIV;
      ST_CDIV: begin
        if (dv_last) begin
          state_d = ST_CFIN;
        end
      end
      ST_CFIN: begin
        state_d = (ch_q == ChBlue) ? ST_EMIT : ST_CMUL;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = last_led ? ST_IDLE : ST_LMUL;
        end
      end
      ST_FILL: begin
        if (slot_free) begin
          state_d = last_led ? ST_IDLE : ST_FILL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EMIT: out_load      = slot_free;
      ST_FILL: out_load      = slot_free;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and state registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_steps_q  <= StepW'(100);
      delay_ms_q    <= TimeW'(1000);
      led_count_q   <= CountW'(60);
      cur_idx_q     <= '0;
      nxt_idx_q     <= '0;
      origin_q      <= '0;
      frame_step_q  <= '0;
      last_change_q <= '0;
      state_q       <= ST_IDLE;
      led_q         <= '0;
      ch_q          <= '0;
      dv_cnt_q      <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        case (paddr[AddrW-1:2])
          RegFadeSteps: fade_steps_q <= pwdata[StepW-1:0];
          RegDelayMs:   delay_ms_q   <= pwdata[TimeW-1:0];
          RegLedCount:  led_count_q  <= pwdata[CountW-1:0];
          default:      ;
        endcase
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          led_q <= '0;
          if (in_accept) begin
            if (s_axis_tuser == CmdStart) begin
              cur_idx_q     <= colour_sat;
              nxt_idx_q     <= colour_sat;
              last_change_q <= in_now;
            end else if (wave_due) begin
              last_change_q <= in_now;
              origin_q      <= origin_sat;
              frame_step_q  <= '0;
              cur_idx_q     <= nxt_idx_q;
              nxt_idx_q     <= colour_sat;
            end
          end
        end
        ST_CHECK: begin
          if (!wave_done) begin
            dv_cnt_q <= DivCntW'(StepW);
          end
        end
        ST_SDIV, ST_CDIV: begin
          dv_cnt_q <= dv_cnt_q - DivCntW'(1);
        end
        ST_LSTEP: begin
          ch_q <= ChRed;
        end
        ST_CLOAD: begin
          dv_cnt_q <= DivCntW'(ChanW);
        end
        ST_CFIN: begin
          ch_q <= ch_q + 2'd1;
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (last_led) begin
              frame_step_q <= frame_step_q + FrameW'(1);
            end else begin
              led_q <= led_q + LedW'(1);
            end
          end
        end
        ST_FILL: begin
          if (slot_free && !last_led) begin
            led_q <= led_q + LedW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_CHECK: begin
        dv_rem_q <= '0;
        dv_sh_q  <= steps;
        dv_div_q <= StepW'(n_leds[CountW-1:1]);
      end
      ST_SDIV: begin
        dv_rem_q <= dv_rem_nx;
        dv_sh_q  <= {dv_sh_q[StepW-2:0], dv_ge};
        if (dv_last) begin
          stride_q <= {dv_sh_q[StepW-2:0], dv_ge};
        end
      end
      ST_LMUL, ST_CMUL: begin
        prod_q <= product;
      end
      ST_LSTEP: begin
        lstep_q <= lstep;
      end
      ST_CLOAD: begin
        // The quotient fits in eight bits, so the upper product bits start
        // out as the partial remainder.
        dv_rem_q <= prod_q[ProdW-1:ChanW];
        dv_sh_q  <= {prod_q[ChanW-1:0], ChanW'(0)};
        dv_div_q <= steps;
      end
      ST_CDIV: begin
        dv_rem_q <= dv_rem_nx;
        dv_sh_q  <= {dv_sh_q[StepW-2:0], dv_ge};
      end
      ST_CFIN: begin
        chan_q[ch_q] <= chan_res;
      end
      default: ;
    endcase

    if (out_load) begin
      m_last_q <= last_led;
      if (state_q == ST_FILL) begin
        m_data_q <= {2'b00, pal_chan(cur_idx_q, ChBlue), pal_chan(cur_idx_q, ChGreen),
                     pal_chan(cur_idx_q, ChRed), led_q};
      end else begin
        m_data_q <= {2'b00, chan_q[2], chan_q[1], chan_q[0], led_q};
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The divider counter only runs in the two divide states.
  a_div_cnt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_cnt_q != '0) |-> (state_q == ST_SDIV || state_q == ST_CDIV))
    else $error("divider counter active outside a divide state");

  // The item that closes a frame belongs to the last LED of the strip.
  a_last_on_final_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[LedW-1:0] == last_idx))
    else $error("tlast not on the final LED");

  // The clamped LED step never exceeds the step count.
  a_lstep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMUL) |-> (lstep_q <= steps))
    else $error("LED step out of range");

  // Palette indexes stay within the palette.
  a_palette_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_idx_q <= ColW'(PaletteSize - 1)) && (nxt_idx_q <= ColW'(PaletteSize - 1)))
    else $error("palette index out of range");

  // A channel never moves further than the distance between its two colours.
  a_quotient_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CFIN) |-> (dv_sh_q[StepW-1:ChanW] == '0 && quo <= chan_diff))
    else $error("blend quotient out of range");
`endif

endmodule
